// ===== rtl/core/qsle_pkg.sv =====
// Shared types and constants of the quicksort engine.
`timescale 1ns / 1ps

package qsle_pkg;

    localparam int DATA_W = 32;

    // One-hot sequencer states.
    typedef enum logic [11:0] {
        S_LOAD    = 12'b0000_0000_0001,
        S_RANGE   = 12'b0000_0000_0010,
        S_PIV     = 12'b0000_0000_0100,
        S_CMP     = 12'b0000_0000_1000,
        S_SW_A    = 12'b0000_0001_0000,
        S_SW_B    = 12'b0000_0010_0000,
        S_FIN_RD  = 12'b0000_0100_0000,
        S_FIN_A   = 12'b0000_1000_0000,
        S_FIN_B   = 12'b0001_0000_0000,
        S_SPLIT   = 12'b0010_0000_0000,
        S_EMIT_RD = 12'b0100_0000_0000,
        S_EMIT_LD = 12'b1000_0000_0000
    } t_state;

endpackage

// ===== rtl/core/qsle_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module qsle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/quicksort_lomuto_engine.sv =====
// Top level of the quicksort engine: loader, partition sequencer and result stream.
`timescale 1ns / 1ps

// Collects signed 32-bit items (one per cycle while loading) until the item
// marked tlast, sorts them in place in ascending order by quicksort with a
// Lomuto partition, and streams them out with tlast on the final one and
// tuser set on every result of the run if items beyond MAX_ELEMENTS were
// dropped. The store is one RAM with a single registered read port, and that
// port sets the timing: a partition of a range reads each element once and
// passes through S_SW_A and S_SW_B on each swap, and already
// ordered data gives the most unbalanced splits. Each result is read
// (S_EMIT_RD), then loaded into the output register (S_EMIT_LD) once the
// output is free. The input is not ready from the last item until
// the last result has been loaded into the output register.

module quicksort_lomuto_engine #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [qsle_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] sample_value
    input  logic                       s_axis_tlast,   // last_item
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [qsle_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] sorted_value
    output logic                       m_axis_tlast,   // end_of_run
    output logic                       m_axis_tuser    // [0] truncated
);

    localparam int IW   = $clog2(MAX_ELEMENTS);
    localparam int CW   = $clog2(MAX_ELEMENTS + 1);
    localparam int SD   = $clog2(MAX_ELEMENTS) + 1;
    localparam int SIW  = $clog2(SD);
    localparam int SPW  = $clog2(SD + 1);
    localparam int DW   = qsle_pkg::DATA_W;

    qsle_pkg::t_state r_state, n_state;

    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;
    logic [CW-1:0]  r_lo, n_lo;
    logic [CW-1:0]  r_hi, n_hi;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_st, n_st;
    logic [CW-1:0]  r_k, n_k;
    logic [SPW-1:0] r_sp, n_sp;
    logic           r_ov, n_ov;
    logic [DW-1:0]  r_pivot, n_pivot;
    logic [DW-1:0]  r_a, n_a;
    logic [DW-1:0]  r_odata;
    logic           r_olast;
    logic           r_ouser;
    logic [CW-1:0]  r_stk_lo [SD];
    logic [CW-1:0]  r_stk_hi [SD];

    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    logic [DW-1:0]  ram_wdata;
    logic [IW-1:0]  ram_raddr;
    logic [DW-1:0]  ram_rdata;

    logic           s_acc;
    logic           store_full;
    logic [CW-1:0]  cnt_new;
    logic           less;
    logic           push;
    logic [CW-1:0]  push_lo;
    logic [CW-1:0]  push_hi;
    logic           out_load;
    logic [SPW-1:0] sp_dec;

    qsle_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == qsle_pkg::S_LOAD);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign store_full    = (r_count >= CW'(MAX_ELEMENTS));
    assign cnt_new       = store_full ? r_count : r_count + CW'(1);
    assign sp_dec        = r_sp - SPW'(1);

    // The one compare unit of the partition loop.
    assign less = ($signed(ram_rdata) < $signed(r_pivot));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_i       = r_i;
        n_st      = r_st;
        n_k       = r_k;
        n_sp      = r_sp;
        n_ov      = r_ov;
        n_pivot   = r_pivot;
        n_a       = r_a;
        ram_we    = 1'b0;
        ram_waddr = r_count[IW-1:0];
        ram_wdata = s_axis_tdata;
        ram_raddr = r_k[IW-1:0];
        push      = 1'b0;
        push_lo   = r_lo;
        push_hi   = r_st - CW'(1);
        out_load  = 1'b0;

        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            qsle_pkg::S_LOAD: begin
                if (s_acc) begin
                    if (store_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = cnt_new;
                    end
                    if (s_axis_tlast) begin
                        n_k  = '0;
                        n_lo = '0;
                        n_hi = cnt_new - CW'(1);
                        n_sp = '0;
                        if (cnt_new < CW'(2)) begin
                            n_state = qsle_pkg::S_EMIT_RD;
                        end else begin
                            n_state = qsle_pkg::S_RANGE;
                        end
                    end
                end
            end
            qsle_pkg::S_RANGE: begin
                ram_raddr = r_hi[IW-1:0];
                if (r_lo < r_hi) begin
                    n_state = qsle_pkg::S_PIV;
                end else if (r_sp != '0) begin
                    n_lo = r_stk_lo[sp_dec[SIW-1:0]];
                    n_hi = r_stk_hi[sp_dec[SIW-1:0]];
                    n_sp = sp_dec;
                end else begin
                    n_k     = '0;
                    n_state = qsle_pkg::S_EMIT_RD;
                end
            end
            qsle_pkg::S_PIV: begin
                n_pivot   = ram_rdata;
                n_i       = r_lo;
                n_st      = r_lo;
                ram_raddr = r_lo[IW-1:0];
                n_state   = qsle_pkg::S_CMP;
            end
            qsle_pkg::S_CMP: begin
                // The loop ends before the pivot at r_hi, which would never test less than itself.
                if (less && (r_i != r_st)) begin
                    n_a       = ram_rdata;
                    ram_raddr = r_st[IW-1:0];
                    n_state   = qsle_pkg::S_SW_A;
                end else begin
                    if (less) begin
                        n_st = r_st + CW'(1);
                    end
                    n_i       = r_i + CW'(1);
                    ram_raddr = n_i[IW-1:0];
                    if (n_i == r_hi) begin
                        n_state = qsle_pkg::S_FIN_RD;
                    end
                end
            end
            qsle_pkg::S_SW_A: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IW-1:0];
                ram_wdata = ram_rdata;
                n_state   = qsle_pkg::S_SW_B;
            end
            qsle_pkg::S_SW_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_st[IW-1:0];
                ram_wdata = r_a;
                n_st      = r_st + CW'(1);
                n_i       = r_i + CW'(1);
                ram_raddr = n_i[IW-1:0];
                if (n_i == r_hi) begin
                    n_state = qsle_pkg::S_FIN_RD;
                end else begin
                    n_state = qsle_pkg::S_CMP;
                end
            end
            qsle_pkg::S_FIN_RD: begin
                ram_raddr = r_st[IW-1:0];
                if (r_st == r_hi) begin
                    n_state = qsle_pkg::S_SPLIT;
                end else begin
                    n_state = qsle_pkg::S_FIN_A;
                end
            end
            qsle_pkg::S_FIN_A: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi[IW-1:0];
                ram_wdata = ram_rdata;
                n_state   = qsle_pkg::S_FIN_B;
            end
            qsle_pkg::S_FIN_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_st[IW-1:0];
                ram_wdata = r_pivot;
                n_state   = qsle_pkg::S_SPLIT;
            end
            qsle_pkg::S_SPLIT: begin
                // r_st is the pivot's final place. Push the larger side and keep the smaller.
                if ((r_st - r_lo) > (r_hi - r_st)) begin
                    if ((r_st > r_lo + CW'(1)) && (r_sp < SPW'(SD))) begin
                        push    = 1'b1;
                        push_lo = r_lo;
                        push_hi = r_st - CW'(1);
                        n_sp    = r_sp + SPW'(1);
                    end
                    n_lo = r_st + CW'(1);
                end else begin
                    if ((r_st + CW'(1) < r_hi) && (r_sp < SPW'(SD))) begin
                        push    = 1'b1;
                        push_lo = r_st + CW'(1);
                        push_hi = r_hi;
                        n_sp    = r_sp + SPW'(1);
                    end
                    // A pivot at index zero leaves an empty left side.
                    if (r_st == '0) begin
                        n_hi = r_lo;
                    end else begin
                        n_hi = r_st - CW'(1);
                    end
                end
                n_state = qsle_pkg::S_RANGE;
            end
            qsle_pkg::S_EMIT_RD: begin
                n_state = qsle_pkg::S_EMIT_LD;
            end
            qsle_pkg::S_EMIT_LD: begin
                if (!r_ov || m_axis_tready) begin
                    out_load = 1'b1;
                    n_ov     = 1'b1;
                    if (r_k == r_count - CW'(1)) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = qsle_pkg::S_LOAD;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = qsle_pkg::S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = qsle_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qsle_pkg::S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_st    <= n_st;
        r_k     <= n_k;
        r_pivot <= n_pivot;
        r_a     <= n_a;
        if (push) begin
            r_stk_lo[r_sp[SIW-1:0]] <= push_lo;
            r_stk_hi[r_sp[SIW-1:0]] <= push_hi;
        end
        if (out_load) begin
            r_odata <= ram_rdata;
            r_olast <= (r_k == r_count - CW'(1));
            r_ouser <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

endmodule

// ===== rtl/core/qsle_checker.sv =====
// Port-level checks of the quicksort engine and their binding to the top level.
`timescale 1ns / 1ps

module qsle_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        s_axis_tlast,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [qsle_pkg::DATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tlast,
    input logic                        m_axis_tuser
);

    logic s_acc;
    logic m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // Reset leaves the engine empty and ready to load.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("engine not idle after reset");

    // The item marked last always starts a sort or an emit.
    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after the last item");

    // The truncation flag is the same on every result of a run.
    a_tuser_per_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && !m_axis_tlast) |=> (!m_axis_tvalid || $stable(m_axis_tuser)))
        else $error("truncation flag changed within a run");

    // No new run can be loaded while an earlier non-final result is pending.
    a_no_load_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input ready in the middle of a run");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind quicksort_lomuto_engine qsle_checker u_qsle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the quicksort engine: random arrays in, sorted runs checked.
`timescale 1ns / 1ps

module testbench;

    localparam int W         = qsle_pkg::DATA_W;
    localparam int CAPACITY  = 64;
    localparam int STALL_MAX = 40000;
    localparam int CALM_FROM = 290;
    localparam int TARGET    = 350;

    typedef enum {
        FILL_RANDOM,
        FILL_CLUSTER,
        FILL_RISING,
        FILL_FALLING,
        FILL_EXTREME
    } fill_t;

    typedef struct {
        logic [W-1:0] value;
        logic         last;
        logic         trunc;
    } sorted_item_t;

    // Mirrors the engine: holds the current array and the sorted items still owed.
    class sort_scoreboard;
        logic signed [W-1:0] held[$];
        bit                  dropped;
        sorted_item_t        owed[$];
        int                  errors;

        function void note_item(logic [W-1:0] v, logic l);
            logic signed [W-1:0] key;
            int                  j;
            sorted_item_t        e;
            if (held.size() < CAPACITY) begin
                held.push_back(v);
            end else begin
                dropped = 1;
            end
            if (!l) return;
            for (int i = 1; i < held.size(); i++) begin
                key = held[i];
                j = i - 1;
                while (j >= 0 && held[j] > key) begin
                    held[j+1] = held[j];
                    j--;
                end
                held[j+1] = key;
            end
            for (int k = 0; k < held.size(); k++) begin
                e.value = held[k];
                e.last  = (k == held.size() - 1);
                e.trunc = dropped;
                owed.push_back(e);
            end
            held.delete();
            dropped = 0;
        endfunction

        function void check_result(logic [W-1:0] v, logic l, logic u);
            sorted_item_t e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %0d last %0b trunc %0b",
                             $signed(v), l, u);
                return;
            end
            e = owed.pop_front();
            if (v !== e.value || l !== e.last || u !== e.trunc) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                             $signed(e.value), e.last, e.trunc, $signed(v), l, u);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_axis_tready;
    logic [W-1:0] s_tdata;       // [31:0] sample_value
    logic         s_tlast;       // last_item
    logic         m_axis_tvalid;
    logic         m_tready;
    logic [W-1:0] m_axis_tdata;  // [31:0] sorted_value
    logic         m_axis_tlast;  // end_of_run
    logic         m_axis_tuser;  // [0] truncated

    sort_scoreboard sb;
    int             items_sent;
    bit             calm;
    int             stall_left;
    int             quiet_cycles;

    quicksort_lomuto_engine #(
        .MAX_ELEMENTS(CAPACITY)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Output side: stalls come in bursts, none once the run has calmed down.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_axis_tready)
                sb.note_item(s_tdata, s_tlast);
            if (m_axis_tvalid && m_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles == STALL_MAX) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Offers one item, possibly after a gap, and returns at the edge that takes it.
    task automatic send_item(input logic [W-1:0] v, input logic l);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= v;
        s_tlast  <= l;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (items_sent >= CALM_FROM) calm = 1;
    endtask

    task automatic send_array(input int len, input fill_t fill);
        logic [W-1:0] v;
        for (int idx = 0; idx < len; idx++) begin
            case (fill)
                FILL_CLUSTER: v = $urandom_range(0, 7) - 4;
                FILL_RISING:  v = 32'h8000_0000 + idx * 32'h0300_0000;
                FILL_FALLING: v = 32'h7FFF_FFFF - idx * 32'h0300_0000;
                FILL_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7FFF_FFFF;
                        2:       v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end
                default:      v = $urandom;
            endcase
            send_item(v, idx == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int    len;
        fill_t fill;
        sb           = new();
        items_sent   = 0;
        calm         = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single element, extremes, duplicates and a short falling run.
        send_item(32'd42, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'd7, 1'b0);
        send_item(32'd7, 1'b0);
        send_item(32'd7, 1'b1);
        send_array(5, FILL_FALLING);

        // Let the whole directed part drain before the overflow and random arrays start.
        wait_drained();

        // A full store of rising data, then a dropped last item, then a long overflow.
        send_array(CAPACITY, FILL_RISING);
        send_array(CAPACITY + 1, FILL_RANDOM);
        send_array(CAPACITY + 6, FILL_CLUSTER);

        while (items_sent < TARGET) begin
            if ($urandom_range(0, 11) == 0)
                len = $urandom_range(40, CAPACITY + 4);
            else
                len = $urandom_range(1, 12);
            fill = fill_t'($urandom_range(0, 4));
            send_array(len, fill);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/qsle_pkg.sv
rtl/core/qsle_ram.sv
rtl/core/quicksort_lomuto_engine.sv
rtl/core/qsle_checker.sv
tb/testbench.sv
